>>> hw/rtl/vector3_fixed_point_alu_top_defines.svh
// Assertion helpers shared by the vector ALU RTL.
`ifndef VECTOR3_FIXED_POINT_ALU_TOP_DEFINES_SVH
`define VECTOR3_FIXED_POINT_ALU_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define V3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define V3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define V3_ASSERT(lbl, prop, msg)
`define V3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OPC_W     = 4;
  localparam int unsigned NUM_LANE  = 3;
  localparam int unsigned NUM_MUL   = 6;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned SAT_W     = 2 * WORD_W + 2;
  localparam int unsigned DVD_W     = WORD_W + FRAC_BITS;
  localparam int unsigned ROOT_W    = WORD_W;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 1;
  localparam int unsigned SH_W      = ROOT_W + 3;

  localparam logic signed [SAT_W-1:0] WORD_MAX =
    {{(SAT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] WORD_MIN =
    {{(SAT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  typedef enum logic [OPC_W-1:0] {
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_DIV,
    OP_DOT,
    OP_CROSS,
    OP_MAG,
    OP_NORM,
    OP_EQ
  } v3alu_op_e;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [WORD_W-1:0] ax;
    logic signed [WORD_W-1:0] ay;
    logic signed [WORD_W-1:0] az;
    logic signed [WORD_W-1:0] bx;
    logic signed [WORD_W-1:0] by;
    logic signed [WORD_W-1:0] bz;
    logic signed [WORD_W-1:0] scalar_in;
  } v3alu_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rx;
    logic signed [WORD_W-1:0] ry;
    logic signed [WORD_W-1:0] rz;
    logic signed [WORD_W-1:0] scalar_out;
    logic                     equal_flag;
    logic                     fault_flag;
  } v3alu_rsp_t;

  // dvd holds |a| << FRAC_BITS on entry to the divider, the quotient on exit
  typedef struct packed {
    logic [OPC_W-1:0]                   opcode;
    v3alu_rsp_t                         res;
    logic [NUM_LANE-1:0]                neg;
    logic [NUM_LANE-1:0][DVD_W-1:0]     dvd;
    logic [WORD_W-1:0]                  dvs;
    logic                               dvs_zero;
  } v3alu_ctx_t;

  // {fault, clamped word}
  function automatic logic [WORD_W:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic [WORD_W:0] r;
    if (v > WORD_MAX) begin
      r = {1'b1, WORD_MAX[WORD_W-1:0]};
    end else if (v < WORD_MIN) begin
      r = {1'b1, WORD_MIN[WORD_W-1:0]};
    end else begin
      r = {1'b0, v[WORD_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/v3alu_front.sv
`default_nettype none

module v3alu_front import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  v3alu_req_t req_i,
  output logic       vld_o,
  output v3alu_ctx_t ctx_o,
  output logic [RAD_W-1:0] rad_o
);

  logic vld0_q, vld1_q, vld2_q;
  v3alu_req_t req0_q, req1_q;

  logic signed [WORD_W-1:0] mul_a [NUM_MUL];
  logic signed [WORD_W-1:0] mul_b [NUM_MUL];
  logic signed [PROD_W-1:0] prod_d [NUM_MUL];
  logic signed [PROD_W-1:0] prod_q [NUM_MUL];

  logic signed [WORD_W-1:0] va [NUM_LANE];
  logic signed [WORD_W-1:0] vb [NUM_LANE];
  logic signed [SAT_W-1:0]  wide [NUM_LANE];
  logic [WORD_W:0]          sat_r [NUM_LANE];
  logic [WORD_W-1:0]        abs_a [NUM_LANE];
  v3alu_rsp_t               res;
  v3alu_ctx_t               ctx_d, ctx_q;
  logic [RAD_W-1:0]         rad_d, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld0_q <= start_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req0_q <= req_i;
    req1_q <= req0_q;
    prod_q <= prod_d;
    ctx_q  <= ctx_d;
    rad_q  <= rad_d;
  end

  // operand select: lanes 0..2 primary products, 3..5 cross subtrahends
  always_comb begin
    mul_a[0] = req0_q.ax;
    mul_a[1] = req0_q.ay;
    mul_a[2] = req0_q.az;
    mul_b[0] = req0_q.bx;
    mul_b[1] = req0_q.by;
    mul_b[2] = req0_q.bz;
    mul_a[3] = req0_q.az;
    mul_b[3] = req0_q.by;
    mul_a[4] = req0_q.ax;
    mul_b[4] = req0_q.bz;
    mul_a[5] = req0_q.ay;
    mul_b[5] = req0_q.bx;
    case (req0_q.opcode)
      OP_SCALE: begin
        mul_b[0] = req0_q.scalar_in;
        mul_b[1] = req0_q.scalar_in;
        mul_b[2] = req0_q.scalar_in;
      end
      OP_CROSS: begin
        mul_a[0] = req0_q.ay;
        mul_b[0] = req0_q.bz;
        mul_a[1] = req0_q.az;
        mul_b[1] = req0_q.bx;
        mul_a[2] = req0_q.ax;
        mul_b[2] = req0_q.by;
      end
      OP_MAG, OP_NORM: begin
        mul_b[0] = req0_q.ax;
        mul_b[1] = req0_q.ay;
        mul_b[2] = req0_q.az;
      end
      default: ;
    endcase
    for (int k = 0; k < NUM_MUL; k++) begin
      prod_d[k] = PROD_W'(mul_a[k]) * PROD_W'(mul_b[k]);
    end
  end

  always_comb begin
    va[0] = req1_q.ax;
    va[1] = req1_q.ay;
    va[2] = req1_q.az;
    vb[0] = req1_q.bx;
    vb[1] = req1_q.by;
    vb[2] = req1_q.bz;

    for (int i = 0; i < NUM_LANE; i++) begin
      wide[i] = '0;
    end
    case (req1_q.opcode)
      OP_ADD: begin
        for (int i = 0; i < NUM_LANE; i++) wide[i] = SAT_W'(va[i]) + SAT_W'(vb[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < NUM_LANE; i++) wide[i] = SAT_W'(va[i]) - SAT_W'(vb[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < NUM_LANE; i++) wide[i] = SAT_W'(prod_q[i]) >>> FRAC_BITS;
      end
      OP_CROSS: begin
        for (int i = 0; i < NUM_LANE; i++) begin
          wide[i] = (SAT_W'(prod_q[i]) - SAT_W'(prod_q[i+3])) >>> FRAC_BITS;
        end
      end
      OP_DOT: begin
        wide[0] = (SAT_W'(prod_q[0]) + SAT_W'(prod_q[1]) + SAT_W'(prod_q[2]))
                  >>> FRAC_BITS;
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_LANE; i++) begin
      sat_r[i] = sat_word(wide[i]);
    end

    res = '0;
    case (req1_q.opcode)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        res.rx         = sat_r[0][WORD_W-1:0];
        res.ry         = sat_r[1][WORD_W-1:0];
        res.rz         = sat_r[2][WORD_W-1:0];
        res.fault_flag = sat_r[0][WORD_W] | sat_r[1][WORD_W] | sat_r[2][WORD_W];
      end
      OP_DOT: begin
        res.scalar_out = sat_r[0][WORD_W-1:0];
        res.fault_flag = sat_r[0][WORD_W];
      end
      OP_DIV: begin
        res.fault_flag = (req1_q.scalar_in == '0);
      end
      OP_NORM: begin
        res.rx = req1_q.ax;
        res.ry = req1_q.ay;
        res.rz = req1_q.az;
      end
      OP_EQ: begin
        res.equal_flag = (va[0] == vb[0]) && (va[1] == vb[1]) && (va[2] == vb[2]);
      end
      default: ;
    endcase

    ctx_d.opcode = req1_q.opcode;
    ctx_d.res    = res;
    for (int i = 0; i < NUM_LANE; i++) begin
      abs_a[i]        = va[i][WORD_W-1] ? WORD_W'(-va[i]) : WORD_W'(va[i]);
      ctx_d.dvd[i]    = {abs_a[i], {FRAC_BITS{1'b0}}};
      ctx_d.neg[i]    = va[i][WORD_W-1] ^
                        ((req1_q.opcode == OP_DIV) & req1_q.scalar_in[WORD_W-1]);
    end
    ctx_d.dvs      = req1_q.scalar_in[WORD_W-1] ? WORD_W'(-req1_q.scalar_in)
                                                : WORD_W'(req1_q.scalar_in);
    ctx_d.dvs_zero = (req1_q.scalar_in == '0);

    rad_d = RAD_W'($unsigned(prod_q[0])) + RAD_W'($unsigned(prod_q[1]))
          + RAD_W'($unsigned(prod_q[2]));
  end

  assign vld_o = vld2_q;
  assign ctx_o = ctx_q;
  assign rad_o = rad_q;

endmodule

`default_nettype wire

>>> hw/rtl/v3alu_sqrt.sv
`default_nettype none

`include "vector3_fixed_point_alu_top_defines.svh"

module v3alu_sqrt import v3alu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  v3alu_ctx_t        ctx_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              vld_o,
  output v3alu_ctx_t        ctx_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              vld_q  [ROOT_W];
  v3alu_ctx_t        ctx_q  [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // one root bit per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              vld_in;
    v3alu_ctx_t        ctx_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic              fit;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    if (i == 0) begin : g_src
      assign vld_in  = vld_i;
      assign ctx_in  = ctx_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_src
      assign vld_in  = vld_q[i-1];
      assign ctx_in  = ctx_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign fit    = (rem_sh >= trial);
    assign rem_d  = fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    assign root_d = {root_in[ROOT_W-2:0], fit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ctx_q[i]  <= ctx_in;
      rad_q[i]  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign ctx_o  = ctx_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];

  `V3_ASSERT(a_sqrt_rem_bound, !vld_q[ROOT_W-1] || (rem_q[ROOT_W-1] <= {root_q[ROOT_W-1], 1'b0}), "sqrt remainder exceeds twice the root")

endmodule

`default_nettype wire

>>> hw/rtl/v3alu_div.sv
`default_nettype none

`include "vector3_fixed_point_alu_top_defines.svh"

module v3alu_div import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  v3alu_ctx_t ctx_i,
  output logic       vld_o,
  output v3alu_ctx_t ctx_o
);

  logic                             vld_q [DVD_W];
  v3alu_ctx_t                       ctx_q [DVD_W];
  logic [NUM_LANE-1:0][WORD_W-1:0]  rem_q [DVD_W];

  // restoring division, one quotient bit per stage, three lanes share the divisor
  for (genvar i = 0; i < DVD_W; i++) begin : g_stage
    logic                            vld_in;
    v3alu_ctx_t                      ctx_in;
    logic [NUM_LANE-1:0][WORD_W-1:0] rem_in;
    logic [NUM_LANE-1:0][WORD_W:0]   sh;
    logic [NUM_LANE-1:0]             ge;
    logic [NUM_LANE-1:0][WORD_W-1:0] rem_d;
    v3alu_ctx_t                      ctx_d;

    if (i == 0) begin : g_src
      assign vld_in = vld_i;
      assign ctx_in = ctx_i;
      assign rem_in = '0;
    end else begin : g_src
      assign vld_in = vld_q[i-1];
      assign ctx_in = ctx_q[i-1];
      assign rem_in = rem_q[i-1];
    end

    always_comb begin
      ctx_d = ctx_in;
      for (int l = 0; l < NUM_LANE; l++) begin
        sh[l]        = {rem_in[l], ctx_in.dvd[l][DVD_W-1]};
        ge[l]        = (sh[l] >= {1'b0, ctx_in.dvs});
        rem_d[l]     = ge[l] ? WORD_W'(sh[l] - {1'b0, ctx_in.dvs}) : sh[l][WORD_W-1:0];
        ctx_d.dvd[l] = {ctx_in.dvd[l][DVD_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ctx_q[i] <= ctx_d;
      rem_q[i] <= rem_d;
    end
  end

  assign vld_o = vld_q[DVD_W-1];
  assign ctx_o = ctx_q[DVD_W-1];

  `V3_ASSERT(a_div_rem_bound, !vld_q[DVD_W-1] || (ctx_q[DVD_W-1].dvs == '0) || ((rem_q[DVD_W-1][0] < ctx_q[DVD_W-1].dvs) && (rem_q[DVD_W-1][1] < ctx_q[DVD_W-1].dvs) && (rem_q[DVD_W-1][2] < ctx_q[DVD_W-1].dvs)), "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> hw/rtl/vector3_fixed_point_alu_top.sv
// Three-component signed fixed-point vector ALU.
// Request channel: drive req_i and pulse start; a request is taken at every
// rising edge with start high and busy low. busy stays low, so a new request
// may be issued in every cycle.
// Result channel: done_o is high for one cycle with rsp_o holding the result.
// The receiver cannot stall; results leave in request order.
// The delay from the accepting edge to the edge that takes the result is the
// same for all opcodes.
// Throughput: one request per cycle. The depth is set by the 32-stage
// bit-serial square root followed by the one-bit-per-stage divider with
// 32 + FRAC_BITS stages, which every request passes through.
// Reset clears all valid bits; requests in flight are dropped and no result
// appears until a new request has gone through the whole pipeline.
`default_nettype none

`include "vector3_fixed_point_alu_top_defines.svh"

module vector3_fixed_point_alu_top import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  v3alu_req_t req_i,
  output logic       done_o,
  output v3alu_rsp_t rsp_o
);

  logic              vld_f;
  v3alu_ctx_t        ctx_f;
  logic [RAD_W-1:0]  rad_f;
  logic              vld_s;
  v3alu_ctx_t        ctx_s;
  logic [ROOT_W-1:0] root_s;
  logic              vld_m_q;
  v3alu_ctx_t        ctx_m_d, ctx_m_q;
  logic              vld_v;
  v3alu_ctx_t        ctx_v;
  logic              done_q;
  v3alu_rsp_t        rsp_d, rsp_q;
  logic signed [SAT_W-1:0] quo_w [NUM_LANE];
  logic [WORD_W:0]         quo_r [NUM_LANE];

  assign busy = 1'b0;

  v3alu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start & ~busy),
    .req_i   (req_i),
    .vld_o   (vld_f),
    .ctx_o   (ctx_f),
    .rad_o   (rad_f)
  );

  v3alu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_f),
    .ctx_i  (ctx_f),
    .rad_i  (rad_f),
    .vld_o  (vld_s),
    .ctx_o  (ctx_s),
    .root_o (root_s)
  );

  always_comb begin
    ctx_m_d = ctx_s;
    case (ctx_s.opcode)
      OP_MAG: begin
        ctx_m_d.res.scalar_out = root_s[ROOT_W-1] ? WORD_MAX[WORD_W-1:0] : root_s;
        ctx_m_d.res.fault_flag = root_s[ROOT_W-1];
      end
      OP_NORM: begin
        ctx_m_d.dvs            = root_s;
        ctx_m_d.dvs_zero       = (root_s == '0);
        ctx_m_d.res.fault_flag = (root_s == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_m_q <= vld_s;
      done_q  <= vld_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_m_q <= ctx_m_d;
    rsp_q   <= rsp_d;
  end

  v3alu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_m_q),
    .ctx_i  (ctx_m_q),
    .vld_o  (vld_v),
    .ctx_o  (ctx_v)
  );

  always_comb begin
    for (int l = 0; l < NUM_LANE; l++) begin
      quo_w[l] = ctx_v.neg[l] ? -SAT_W'(ctx_v.dvd[l]) : SAT_W'(ctx_v.dvd[l]);
      quo_r[l] = sat_word(quo_w[l]);
    end
    rsp_d = ctx_v.res;
    if (((ctx_v.opcode == OP_DIV) || (ctx_v.opcode == OP_NORM)) && !ctx_v.dvs_zero) begin
      rsp_d.rx         = quo_r[0][WORD_W-1:0];
      rsp_d.ry         = quo_r[1][WORD_W-1:0];
      rsp_d.rz         = quo_r[2][WORD_W-1:0];
      rsp_d.fault_flag = quo_r[0][WORD_W] | quo_r[1][WORD_W] | quo_r[2][WORD_W];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `V3_ASSERT(a_eq_no_fault, !done_o || !(rsp_o.equal_flag && rsp_o.fault_flag), "equality result flagged a fault")
  `V3_ASSERT_NEXT(a_norm_zero_fault, vld_s && (ctx_s.opcode == OP_NORM) && (root_s == '0), ctx_m_q.res.fault_flag && ctx_m_q.dvs_zero, "zero-length normalize not flagged")
  `V3_ASSERT_NEXT(a_div_to_done, vld_v, done_o, "divider output did not reach the result register")

endmodule

`default_nettype wire

>>> sim/v3alu_checker.sv
`default_nettype none

module v3alu_checker import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  v3alu_req_t req_i,
  input  logic       done_i,
  input  v3alu_rsp_t rsp_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [79:0] wide_t;

  v3alu_rsp_t expected_results[$];
  int         mismatch_count;

  function automatic logic [WORD_W:0] clamp_word(input wide_t v);
    if (v > 80'sh7FFF_FFFF) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -80'sh8000_0000) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[WORD_W-1:0]};
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic v3alu_rsp_t vector_alu_result(input v3alu_req_t r);
    v3alu_rsp_t  o;
    wide_t       a [3];
    wide_t       b [3];
    wide_t       s;
    wide_t       v [3];
    wide_t       mag;
    logic [63:0] sq;
    logic [WORD_W:0] c [3];
    logic        flt;
    o = '0;
    flt = 1'b0;
    a[0] = $signed(r.ax); a[1] = $signed(r.ay); a[2] = $signed(r.az);
    b[0] = $signed(r.bx); b[1] = $signed(r.by); b[2] = $signed(r.bz);
    s = $signed(r.scalar_in);
    for (int i = 0; i < 3; i++) v[i] = '0;
    case (r.opcode)
      OP_ADD:   for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      OP_SUB:   for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FRAC_BITS;
      OP_DIV: begin
        if (s == 0) flt = 1'b1;
        else for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_BITS) / s;
      end
      OP_CROSS: begin
        v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS;
        v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS;
        v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS;
      end
      OP_DOT: begin
        c[0] = clamp_word((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC_BITS);
        o.scalar_out = c[0][WORD_W-1:0];
        flt = c[0][WORD_W];
      end
      OP_MAG, OP_NORM: begin
        sq = '0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        mag = $signed({16'b0, int_sqrt(sq)});
        if (r.opcode == OP_MAG) begin
          c[0] = clamp_word(mag);
          o.scalar_out = c[0][WORD_W-1:0];
          flt = c[0][WORD_W];
        end else if (mag == 0) begin
          flt = 1'b1;
          for (int i = 0; i < 3; i++) v[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_BITS) / mag;
        end
      end
      OP_EQ: o.equal_flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      c[i] = clamp_word(v[i]);
      flt = flt | c[i][WORD_W];
    end
    o.rx = c[0][WORD_W-1:0];
    o.ry = c[1][WORD_W-1:0];
    o.rz = c[2][WORD_W-1:0];
    o.fault_flag = flt;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    v3alu_rsp_t want;
    if (!rst_ni) begin
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result %h", rsp_i);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (rsp_i.rx !== want.rx || rsp_i.ry !== want.ry || rsp_i.rz !== want.rz ||
              rsp_i.scalar_out !== want.scalar_out ||
              rsp_i.equal_flag !== want.equal_flag ||
              rsp_i.fault_flag !== want.fault_flag) begin
            if (mismatch_count < 10) begin
              $display("mismatch: expected rx %h ry %h rz %h sc %h eq %b flt %b",
                       want.rx, want.ry, want.rz, want.scalar_out,
                       want.equal_flag, want.fault_flag);
              $display("          actual   rx %h ry %h rz %h sc %h eq %b flt %b",
                       rsp_i.rx, rsp_i.ry, rsp_i.rz, rsp_i.scalar_out,
                       rsp_i.equal_flag, rsp_i.fault_flag);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start_i && !busy_i) expected_results.push_back(vector_alu_result(req_i));
    end
  end

  assign fail_count_o = mismatch_count;
  assign pending_o    = expected_results.size();

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top import v3alu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  v3alu_req_t req = '0;
  logic       done;
  v3alu_rsp_t rsp;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         idle_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vector3_fixed_point_alu_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  v3alu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      3: return 32'($urandom_range(0, 32'h3FF_FFFF)) - 32'h200_0000;
      4: return 32'($urandom_range(0, 8)) << 16;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input v3alu_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    #0.1;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic issue_fields(input logic [3:0] op, input logic [31:0] a0, a1, a2,
                              input logic [31:0] b0, b1, b2, s);
    v3alu_req_t r;
    r.opcode = op;
    r.ax = a0; r.ay = a1; r.az = a2;
    r.bx = b0; r.by = b1; r.bz = b2;
    r.scalar_in = s;
    issue_request(r);
  endtask

  task automatic issue_random();
    v3alu_req_t r;
    r.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
    r.ax = pick_word(); r.ay = pick_word(); r.az = pick_word();
    r.bx = pick_word(); r.by = pick_word(); r.bz = pick_word();
    r.scalar_in = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_word();
    if (r.opcode == OP_EQ && $urandom_range(0, 1)) begin
      r.bx = r.ax; r.by = r.ay; r.bz = r.az;
      if ($urandom_range(0, 3) == 0) r.bz = r.bz ^ (32'd1 << $urandom_range(0, 31));
    end
    if (r.opcode == OP_NORM && $urandom_range(0, 7) == 0) begin
      r.ax = '0; r.ay = '0; r.az = '0;
    end
    issue_request(r);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue_fields(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 32'hFFFF_FFFF,
                 32'h2, 32'h0);
    issue_fields(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h1, 32'hFFFF_FFFF,
                 32'h7, 32'h0);
    issue_fields(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0,
                 32'h8000_0000);
    issue_fields(OP_SCALE, 32'h0001_8000, 32'hFFFF_FFFF, 32'h3, 0, 0, 0, 32'h0000_8000);
    issue_fields(OP_DIV, 32'h0003_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, 0, 0, 32'h0);
    issue_fields(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFD_0000, 0, 0, 0,
                 32'h0000_0001);
    issue_fields(OP_DIV, 32'h8000_0000, 32'h0007_0000, 32'hFFFF_FFFF, 0, 0, 0,
                 32'hFFFF_FFFF);
    issue_fields(OP_DIV, 32'h0001_0000, 32'hFFFF_0000, 32'h5, 0, 0, 0, 32'h0003_0000);
    issue_fields(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h0);
    issue_fields(OP_DOT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    issue_fields(OP_DOT, 32'h0002_0000, 32'hFFFF_FFFF, 32'h3, 32'h0001_8000,
                 32'h1, 32'hFFFF_FFFF, 32'h0);
    issue_fields(OP_CROSS, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h0);
    issue_fields(OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                 32'h0, 32'h0);
    issue_fields(OP_CROSS, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFD, 32'h5, 32'hFFFF_FFFF,
                 32'h2, 32'h0);
    issue_fields(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    issue_fields(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 0, 0, 0, 0);
    issue_fields(OP_MAG, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    issue_fields(OP_NORM, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
    issue_fields(OP_NORM, 32'h0, 32'h0, 32'h1, 0, 0, 0, 0);
    issue_fields(OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    issue_fields(OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 0, 0, 0, 0);
    issue_fields(OP_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h0, 32'h0);
    issue_fields(OP_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h1, 32'h0);
    issue_fields(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_fields(4'd15, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7);

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    idle_pct = 6;
    repeat (400) issue_random();
    idle_pct = 86;
    repeat (400) issue_random();
    idle_pct = 0;
    repeat (350) issue_random();
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
